// ----- hdl/three_axis_pid_quad_mixer_assert.svh -----
// Assertion macros shared by the quad mixer RTL.
// Needs i_clk and i_rst_n in the including module's scope.
`ifndef THREE_AXIS_PID_QUAD_MIXER_ASSERT_SVH
`define THREE_AXIS_PID_QUAD_MIXER_ASSERT_SVH

// same-cycle implication
`define QMX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QMX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/qmx_pkg.sv -----
// Package of the three-axis PID quad mixer: widths, types, register codes
// and the motor output function. No dependencies.
`default_nettype none

package qmx_pkg;

    localparam int AccW     = 104;
    localparam int MixW     = 106;
    localparam int DivSteps = 37;
    localparam int MulSteps = 7;
    localparam int CntW     = 6;

    localparam logic [11:0] M1_LO  = 12'd229;
    localparam logic [11:0] M1_HI  = 12'd420;
    localparam logic [11:0] M2_LO  = 12'd210;
    localparam logic [11:0] M2_HI  = 12'd409;
    localparam logic [11:0] M34_LO = 12'd220;
    localparam logic [11:0] M34_HI = 12'd420;
    localparam logic [20:0] MIX_SAT = 21'h100000;

    typedef logic signed [AccW-1:0] t_acc;
    typedef logic signed [MixW-1:0] t_mix;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL, S_MIX, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        REG_KP, REG_KI, REG_KD, REG_DB, REG_THR
    } t_reg_idx;

    typedef enum logic [2:0] {
        M_KP, M_KI0, M_KI1, M_KI2, M_KD0, M_KD1, M_KD2
    } t_mul_sel;

    typedef struct packed {
        logic     init;
        logic     div_en;
        logic     mul_en;
        t_mul_sel mul_sel;
    } t_lane_ctl;

    function automatic logic [11:0] qmx_motor(input t_mix v, input logic [11:0] thr,
                                              input logic [11:0] lo, input logic [11:0] hi);
        logic [MixW-1:0]  mag;
        logic [MixW-49:0] q;
        logic [20:0]      qs;
        logic signed [23:0] t;
        mag = v[MixW-1] ? MixW'(-v) : MixW'(v);
        q   = mag[MixW-1:48];
        qs  = (q > (MixW-48)'(MIX_SAT)) ? MIX_SAT : q[20:0];
        t   = $signed({12'b0, thr}) +
              (v[MixW-1] ? -$signed({3'b0, qs}) : $signed({3'b0, qs}));
        if (t < $signed({12'b0, lo})) t = $signed({12'b0, lo});
        if (t > $signed({12'b0, hi})) t = $signed({12'b0, hi});
        return t[11:0];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/three_axis_pid_quad_mixer.sv -----
// Top level: three PID lanes, X mixer, sequencer and register port.
// Depends on qmx_pkg, qmx_lane and qmx_mixer.
//
//  channel   handshake                 payload
//  in        i_in_valid / o_in_stall   targets, angles, throttle, delta time
//  out       o_out_valid / i_out_stall motor_one..four, integral_saturated
//  cfg       psel/penable/pwrite/pready 5 registers at 4*i
//
// An item passes through an accept step, 37 divider steps of the derivative
// (one quotient bit per cycle), 7 multiply-accumulate steps on the 32x16
// multiplier of each lane, a mix step and an output load.
// Synchronous active-low reset restores register defaults and clears axis state.
// A stalled result holds the block in its last step; the next input is taken
// in the idle step that follows the load of the result into the output register.
`default_nettype none

module three_axis_pid_quad_mixer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_roll_target,
    input  logic signed [15:0] i_pitch_target,
    input  logic signed [15:0] i_yaw_target,
    input  logic signed [15:0] i_roll_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_yaw_angle,
    input  logic [11:0]        i_throttle_in,
    input  logic [15:0]        i_delta_time_us,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [11:0]        o_motor_one,
    output logic [11:0]        o_motor_two,
    output logic [11:0]        o_motor_three,
    output logic [11:0]        o_motor_four,
    output logic               o_integral_saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import qmx_pkg::*;

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [31:0]     r_kp, r_ki, r_kd;
    logic [14:0]     r_db;
    logic [11:0]     r_thr_lim;
    logic [15:0]     r_dt;
    logic [11:0]     r_thr;
    logic            r_out_valid;
    logic [11:0]     r_m1, r_m2, r_m3, r_m4;
    logic            r_flag;

    t_lane_ctl   w_ctl;
    logic        w_accept, w_wr, w_mix_en, w_load, w_held;
    logic [15:0] w_dt_in, w_dt;
    t_acc        w_c_roll, w_c_pitch, w_c_yaw;
    logic        w_s_roll, w_s_pitch, w_s_yaw;
    logic [11:0] w_m1, w_m2, w_m3, w_m4;

    assign pready   = 1'b1;
    assign w_wr     = psel && penable && pwrite;
    assign w_accept = i_in_valid && !o_in_stall;
    assign w_held   = r_out_valid && i_out_stall;
    assign w_dt_in  = (i_delta_time_us == '0) ? 16'd1 : i_delta_time_us;
    assign w_dt     = (r_state == S_IDLE) ? w_dt_in : r_dt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= 32'd524288;
            r_ki      <= 32'd1049;
            r_kd      <= 32'd524288000;
            r_db      <= 15'd512;
            r_thr_lim <= 12'd420;
        end else if (w_wr) begin
            unique case (t_reg_idx'(paddr[4:2]))
                REG_KP:  r_kp      <= pwdata;
                REG_KI:  r_ki      <= pwdata;
                REG_KD:  r_kd      <= pwdata;
                REG_DB:  r_db      <= pwdata[14:0];
                REG_THR: r_thr_lim <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg_idx'(paddr[4:2]))
            REG_KP:  prdata = r_kp;
            REG_KI:  prdata = r_ki;
            REG_KD:  prdata = r_kd;
            REG_DB:  prdata = {17'b0, r_db};
            REG_THR: prdata = {20'b0, r_thr_lim};
            default: prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_accept) n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CntW'(DivSteps-1)) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MUL: begin
                if (r_cnt == CntW'(MulSteps-1)) begin
                    n_state = S_MIX;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_MIX: n_state = S_OUT;
            S_OUT: if (!w_held) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall    = (r_state != S_IDLE);
        w_ctl.init    = w_accept;
        w_ctl.div_en  = (r_state == S_DIV);
        w_ctl.mul_en  = (r_state == S_MUL);
        w_ctl.mul_sel = t_mul_sel'(r_cnt[2:0]);
        w_mix_en      = (r_state == S_MIX);
        w_load        = (r_state == S_OUT) && !w_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dt  <= w_dt_in;
            r_thr <= (i_throttle_in > r_thr_lim) ? r_thr_lim : i_throttle_in;
        end
        if (w_load) begin
            r_m1   <= w_m1;
            r_m2   <= w_m2;
            r_m3   <= w_m3;
            r_m4   <= w_m4;
            r_flag <= w_s_roll || w_s_pitch || w_s_yaw;
        end
    end

    qmx_lane u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_target(i_roll_target), .i_angle(i_roll_angle), .i_dt(w_dt),
        .i_kp(r_kp), .i_ki(r_ki), .i_kd(r_kd), .i_deadband(r_db),
        .o_ctrl(w_c_roll), .o_sat(w_s_roll)
    );

    qmx_lane u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_target(i_pitch_target), .i_angle(i_pitch_angle), .i_dt(w_dt),
        .i_kp(r_kp), .i_ki(r_ki), .i_kd(r_kd), .i_deadband(r_db),
        .o_ctrl(w_c_pitch), .o_sat(w_s_pitch)
    );

    qmx_lane u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(w_ctl),
        .i_target(i_yaw_target), .i_angle(i_yaw_angle), .i_dt(w_dt),
        .i_kp(r_kp), .i_ki(r_ki), .i_kd(r_kd), .i_deadband(r_db),
        .o_ctrl(w_c_yaw), .o_sat(w_s_yaw)
    );

    qmx_mixer u_mixer (
        .i_clk(i_clk), .i_en(w_mix_en),
        .i_roll(w_c_roll), .i_pitch(w_c_pitch), .i_yaw(w_c_yaw), .i_thr(r_thr),
        .o_m1(w_m1), .o_m2(w_m2), .o_m3(w_m3), .o_m4(w_m4)
    );

    assign o_out_valid          = r_out_valid;
    assign o_motor_one          = r_m1;
    assign o_motor_two          = r_m2;
    assign o_motor_three        = r_m3;
    assign o_motor_four         = r_m4;
    assign o_integral_saturated = r_flag;

`include "three_axis_pid_quad_mixer_assert.svh"

    `QMX_ASSERT_NXT(a_accept_starts_div, w_accept, r_state == S_DIV, "accepted item did not start divide")
    `QMX_ASSERT_NXT(a_div_to_mul, (r_state == S_DIV) && (r_cnt == CntW'(DivSteps-1)), r_state == S_MUL, "divide did not hand over to multiply")
    `QMX_ASSERT_NOW(a_load_from_out, $rose(r_out_valid), $past(r_state) == S_OUT, "result appeared outside output step")

endmodule

`default_nettype wire

// ----- hdl/qmx_lane.sv -----
// One axis lane: error, saturating integral, bit-serial derivative divide
// and a 32x16 multiply-accumulate over the gains. Uses qmx_pkg.
`default_nettype none

module qmx_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qmx_pkg::t_lane_ctl  i_ctl,
    input  logic signed [15:0]  i_target,
    input  logic signed [15:0]  i_angle,
    input  logic [15:0]         i_dt,
    input  logic [31:0]         i_kp,
    input  logic [31:0]         i_ki,
    input  logic [31:0]         i_kd,
    input  logic [14:0]         i_deadband,
    output qmx_pkg::t_acc       o_ctrl,
    output logic                o_sat
);
    import qmx_pkg::*;

    logic signed [16:0] r_prev;
    logic signed [47:0] r_int;
    logic               r_sat;
    logic               r_e_neg, r_s_neg, r_d_neg;
    logic [15:0]        r_e_mag;
    logic [47:0]        r_s_mag;
    logic [36:0]        r_dvd;
    logic [15:0]        r_rem;
    t_acc               r_acc;

    logic signed [16:0] w_err;
    logic signed [17:0] w_diff;
    logic signed [33:0] w_edt;
    logic signed [49:0] w_sum;
    logic signed [47:0] w_snew;
    logic               w_clip, w_dead;
    logic [16:0]        w_emag, w_dmag, w_rsh;
    logic               w_ge;
    logic [31:0]        w_gain;
    logic [15:0]        w_chunk;
    logic [6:0]         w_shift;
    logic               w_neg;
    logic [47:0]        w_prod, w_quo48;
    logic [AccW-1:0]    w_term;

    always_comb begin
        w_err  = {i_target[15], i_target} - {i_angle[15], i_angle};
        w_diff = {w_err[16], w_err} - {r_prev[16], r_prev};
        w_edt  = w_err * $signed({1'b0, i_dt});
        w_sum  = {{2{r_int[47]}}, r_int} + {{16{w_edt[33]}}, w_edt};
        w_clip = (w_sum[49:47] != 3'b000) && (w_sum[49:47] != 3'b111);
        if (w_clip) begin
            w_snew = w_sum[49] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end else begin
            w_snew = w_sum[47:0];
        end
        w_emag = w_err[16] ? 17'(-w_err) : 17'(w_err);
        w_dead = w_emag < {2'b0, i_deadband};
        if (w_dead) w_snew = '0;
        w_dmag = w_diff[17] ? 17'(-w_diff) : 17'(w_diff);
        w_rsh  = {r_rem, r_dvd[36]};
        w_ge   = w_rsh >= {1'b0, i_dt};
    end

    always_comb begin
        w_quo48 = {11'b0, r_dvd};
        unique case (i_ctl.mul_sel)
            M_KP:  begin w_gain = i_kp; w_chunk = r_e_mag;         w_shift = 7'd20; w_neg = r_e_neg; end
            M_KI0: begin w_gain = i_ki; w_chunk = r_s_mag[15:0];   w_shift = 7'd20; w_neg = r_s_neg; end
            M_KI1: begin w_gain = i_ki; w_chunk = r_s_mag[31:16];  w_shift = 7'd36; w_neg = r_s_neg; end
            M_KI2: begin w_gain = i_ki; w_chunk = r_s_mag[47:32];  w_shift = 7'd52; w_neg = r_s_neg; end
            M_KD0: begin w_gain = i_kd; w_chunk = w_quo48[15:0];   w_shift = 7'd0;  w_neg = r_d_neg; end
            M_KD1: begin w_gain = i_kd; w_chunk = w_quo48[31:16];  w_shift = 7'd16; w_neg = r_d_neg; end
            M_KD2: begin w_gain = i_kd; w_chunk = w_quo48[47:32];  w_shift = 7'd32; w_neg = r_d_neg; end
            default: begin w_gain = '0; w_chunk = '0; w_shift = '0; w_neg = 1'b0; end
        endcase
        w_prod = w_gain * w_chunk;
        w_term = {{(AccW-48){1'b0}}, w_prod} << w_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_int  <= '0;
            r_sat  <= 1'b0;
        end else if (i_ctl.init) begin
            r_prev <= w_err;
            r_int  <= w_snew;
            r_sat  <= w_clip && !w_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_e_neg <= w_err[16];
            r_e_mag <= w_emag[15:0];
            r_s_neg <= w_snew[47];
            r_s_mag <= w_snew[47] ? 48'(-w_snew) : 48'(w_snew);
            r_d_neg <= w_diff[17];
            r_dvd   <= {w_dmag, 20'b0};
            r_rem   <= '0;
            r_acc   <= '0;
        end else if (i_ctl.div_en) begin
            r_rem <= w_ge ? 16'(w_rsh - {1'b0, i_dt}) : w_rsh[15:0];
            r_dvd <= {r_dvd[35:0], w_ge};
        end else if (i_ctl.mul_en) begin
            r_acc <= r_acc + (w_neg ? $signed(-w_term) : $signed(w_term));
        end
    end

    assign o_ctrl = r_acc;
    assign o_sat  = r_sat;

`include "three_axis_pid_quad_mixer_assert.svh"

    `QMX_ASSERT_NXT(a_rem_below_dt, i_ctl.div_en, {1'b0, r_rem} < {1'b0, i_dt}, "divider remainder not below divisor")
    `QMX_ASSERT_NXT(a_init_clears_acc, i_ctl.init, r_acc == '0, "accumulator not cleared at start")
    `QMX_ASSERT_NOW(a_ctl_excl, 1'b1, $onehot0({i_ctl.init, i_ctl.div_en, i_ctl.mul_en}), "lane controls overlap")

endmodule

`default_nettype wire

// ----- hdl/qmx_mixer.sv -----
// Merge stage: X mix of the three axis controls, then truncation, saturation,
// throttle add and motor clamps. Uses qmx_pkg.
`default_nettype none

module qmx_mixer (
    input  logic          i_clk,
    input  logic          i_en,
    input  qmx_pkg::t_acc i_roll,
    input  qmx_pkg::t_acc i_pitch,
    input  qmx_pkg::t_acc i_yaw,
    input  logic [11:0]   i_thr,
    output logic [11:0]   o_m1,
    output logic [11:0]   o_m2,
    output logic [11:0]   o_m3,
    output logic [11:0]   o_m4
);
    import qmx_pkg::*;

    t_mix r_s1, r_s2, r_s3, r_s4;
    t_mix w_r, w_p, w_y;

    assign w_r = MixW'(i_roll);
    assign w_p = MixW'(i_pitch);
    assign w_y = MixW'(i_yaw);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= w_p - w_r - w_y;
            r_s2 <= w_r + w_y + w_p;
            r_s3 <= w_r - w_y - w_p;
            r_s4 <= w_y - w_r - w_p;
        end
    end

    assign o_m1 = qmx_motor(r_s1, i_thr, M1_LO, M1_HI);
    assign o_m2 = qmx_motor(r_s2, i_thr, M2_LO, M2_HI);
    assign o_m3 = qmx_motor(r_s3, i_thr, M34_LO, M34_HI);
    assign o_m4 = qmx_motor(r_s4, i_thr, M34_LO, M34_HI);

endmodule

`default_nettype wire

// ----- tb/sv/three_axis_pid_quad_mixer_tb.sv -----
// Testbench of the three-axis PID quad mixer: random and directed attitude commands,
// a self-checking flight-law predictor and APB register writes. Depends on qmx_pkg and the RTL.
// Each transfer on the result channel is checked against the oldest predicted motor set.
module three_axis_pid_quad_mixer_tb;
    import qmx_pkg::*;

    localparam longint LIM48 = 64'sh7FFF_FFFF_FFFF;
    localparam int     RUN_LIMIT = 5_000_000;
    localparam int     UNUSED_REG = 5;

    typedef struct {
        logic signed [15:0] rt, pt, yt, ra, pa, ya;
        logic [11:0]        thr;
        logic [15:0]        dt;
    } flight_cmd_t;

    typedef struct {
        logic [11:0] m1, m2, m3, m4;
        logic        sat;
    } motor_cmd_t;

    class mixer_scoreboard;
        logic [31:0] kp, ki, kd;
        logic [14:0] deadband;
        logic [11:0] thr_limit;
        longint      last_err[3];
        longint      integ[3];
        motor_cmd_t  pending[$];
        int          fails;

        function new();
            kp = 32'd524288;
            ki = 32'd1049;
            kd = 32'd524288000;
            deadband = 15'd512;
            thr_limit = 12'd420;
            fails = 0;
            for (int i = 0; i < 3; i++) begin
                last_err[i] = 0;
                integ[i] = 0;
            end
        endfunction

        function void write_reg(int idx, logic [31:0] v);
            case (idx)
                REG_KP: kp = v;
                REG_KI: ki = v;
                REG_KD: kd = v;
                REG_DB: deadband = v[14:0];
                REG_THR: thr_limit = v[11:0];
                default: ;
            endcase
        endfunction

        function logic signed [127:0] axis_law(int a, longint tgt, longint ang, longint dt,
                                               inout bit flag);
            longint e, diff, s, dmag, dq;
            bit clip;
            logic signed [127:0] ew, sw, dw, kpw, kiw, kdw;
            e = tgt - ang;
            diff = e - last_err[a];
            s = integ[a] + e * dt;
            clip = 0;
            if (s > LIM48) begin
                s = LIM48;
                clip = 1;
            end
            if (s < -LIM48 - 1) begin
                s = -LIM48 - 1;
                clip = 1;
            end
            if ((e < 0 ? -e : e) < longint'(deadband)) begin
                s = 0;
                clip = 0;
            end
            flag |= clip;
            integ[a] = s;
            last_err[a] = e;
            dmag = diff < 0 ? -diff : diff;
            dq = (dmag << 20) / dt;
            if (diff < 0) dq = -dq;
            ew = e;
            sw = s;
            dw = dq;
            kpw = {96'd0, kp};
            kiw = {96'd0, ki};
            kdw = {96'd0, kd};
            return ((ew * kpw + sw * kiw) <<< 20) + dw * kdw;
        endfunction

        function logic [11:0] motor_out(logic signed [127:0] v, longint thr, longint lo,
                                        longint hi);
            logic [127:0] mag, whole;
            longint q, t;
            mag = v < 0 ? -v : v;
            whole = mag >> 48;
            q = (whole > 128'(MIX_SAT)) ? longint'(MIX_SAT) : longint'(whole[20:0]);
            t = thr + (v < 0 ? -q : q);
            if (t < lo) t = lo;
            if (t > hi) t = hi;
            return t[11:0];
        endfunction

        function void note_input(flight_cmd_t c);
            longint dt, thr;
            bit flag;
            logic signed [127:0] r, p, y;
            motor_cmd_t m;
            dt = (c.dt == 0) ? 1 : c.dt;
            thr = (c.thr > thr_limit) ? thr_limit : c.thr;
            flag = 0;
            r = axis_law(0, c.rt, c.ra, dt, flag);
            p = axis_law(1, c.pt, c.pa, dt, flag);
            y = axis_law(2, c.yt, c.ya, dt, flag);
            m.m1 = motor_out(p - (r + y), thr, M1_LO, M1_HI);
            m.m2 = motor_out(r + y + p, thr, M2_LO, M2_HI);
            m.m3 = motor_out(r - (y + p), thr, M34_LO, M34_HI);
            m.m4 = motor_out(y - (r + p), thr, M34_LO, M34_HI);
            m.sat = flag;
            pending.push_back(m);
        endfunction

        function void check(motor_cmd_t got);
            motor_cmd_t want;
            logic [11:0] w[5], g[5];
            string names[5] = '{"motor_one", "motor_two", "motor_three", "motor_four",
                                "integral_saturated"};
            if (pending.size() == 0) begin
                $display("%0t: unexpected transfer motor_one=%0d", $time, got.m1);
                fails++;
                return;
            end
            want = pending.pop_front();
            w = '{want.m1, want.m2, want.m3, want.m4, 12'(want.sat)};
            g = '{got.m1, got.m2, got.m3, got.m4, 12'(got.sat)};
            for (int i = 0; i < 5; i++) begin
                if (w[i] !== g[i]) begin
                    $display("%0t: %s expected %0d actual %0d", $time, names[i], w[i], g[i]);
                    fails++;
                end
            end
        endfunction
    endclass

    logic               i_clk, i_rst_n;
    logic               i_in_valid, o_in_stall;
    logic signed [15:0] i_roll_target, i_pitch_target, i_yaw_target;
    logic signed [15:0] i_roll_angle, i_pitch_angle, i_yaw_angle;
    logic [11:0]        i_throttle_in;
    logic [15:0]        i_delta_time_us;
    logic               o_out_valid, i_out_stall;
    logic [11:0]        o_motor_one, o_motor_two, o_motor_three, o_motor_four;
    logic               o_integral_saturated;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;

    mixer_scoreboard sb = new();
    int  tx_idle = 21, rx_idle = 71;
    int  hold_left = 0;
    bit  hold_req = 0;
    int  cycles = 0;

    three_axis_pid_quad_mixer dut (.*);

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // outputs and stall are stable here for the coming rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check('{o_motor_one, o_motor_two, o_motor_three, o_motor_four,
                       o_integral_saturated});
    end

    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle);
        end
    end

    function automatic flight_cmd_t mk_cmd(int rt, int pt, int yt, int ra, int pa, int ya,
                                           int thr, int dt);
        flight_cmd_t c;
        c = '{16'(rt), 16'(pt), 16'(yt), 16'(ra), 16'(pa), 16'(ya), 12'(thr), 16'(dt)};
        return c;
    endfunction

    function automatic flight_cmd_t rand_cmd();
        flight_cmd_t c;
        int kind;
        kind = $urandom_range(9);
        c = mk_cmd($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        if (kind < 4) begin
            c.ra = c.rt + 16'($signed($urandom_range(2048)) - 1024);
            c.pa = c.pt + 16'($signed($urandom_range(2048)) - 1024);
            c.ya = c.yt + 16'($signed($urandom_range(2048)) - 1024);
        end
        if (kind == 5) c.dt = 16'($urandom_range(8));
        if (kind == 6) c.thr = 12'($urandom_range(500));
        return c;
    endfunction

    task automatic send_cmd(flight_cmd_t c);
        bit stalled;
        while ($urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_roll_target <= c.rt;
        i_pitch_target <= c.pt;
        i_yaw_target <= c.yt;
        i_roll_angle <= c.ra;
        i_pitch_angle <= c.pa;
        i_yaw_angle <= c.ya;
        i_throttle_in <= c.thr;
        i_delta_time_us <= c.dt;
        i_in_valid <= 1'b1;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        sb.note_input(c);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx * 4);
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    task automatic write_all(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                             logic [31:0] db, logic [31:0] thr);
        apb_write(REG_KP, kp);
        apb_write(REG_KI, ki);
        apb_write(REG_KD, kd);
        apb_write(REG_DB, db);
        apb_write(REG_THR, thr);
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0;
        i_in_valid = 0;
        i_out_stall = 0;
        {i_roll_target, i_pitch_target, i_yaw_target} = '0;
        {i_roll_angle, i_pitch_angle, i_yaw_angle} = '0;
        i_throttle_in = 0;
        i_delta_time_us = 1;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero time, throttle clamp, deadband edges
        send_cmd(mk_cmd(0, 0, 0, 0, 0, 0, 0, 1));
        send_cmd(mk_cmd(32767, -32768, 32767, -32768, 32767, -32768, 4095, 65535));
        send_cmd(mk_cmd(-32768, 32767, -32768, 32767, -32768, 32767, 4095, 1));
        send_cmd(mk_cmd(32767, 32767, 32767, -32768, -32768, -32768, 420, 0));
        send_cmd(mk_cmd(-32768, -32768, -32768, 32767, 32767, 32767, 421, 0));
        send_cmd(mk_cmd(100, -100, 511, 0, 0, 0, 300, 1000));
        send_cmd(mk_cmd(512, -512, 513, 0, 0, 0, 300, 1000));
        send_cmd(mk_cmd(-511, 512, -513, 0, 0, 0, 0, 20000));
        send_cmd(mk_cmd(1000, 0, 0, 0, 1000, 0, 4095, 2));
        send_cmd(mk_cmd(0, 0, 1000, 0, 0, 0, 400, 65535));
        send_cmd(mk_cmd(-1, -1, -1, 0, 0, 0, 4095, 65535));
        send_cmd(mk_cmd(0, 0, 0, 0, 0, 0, 4095, 0));
        drain();
        apb_write(UNUSED_REG, 32'hFFFF_FFFF);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 2 || ph == 3) begin
                tx_idle = 71;
                rx_idle = 21;
            end else if (ph >= 4) begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case (ph)
                0: ;
                1: write_all('1, '1, '1, 0, 4095);
                2: write_all(0, 0, 0, '1, 0);
                default: write_all($urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
                                   $urandom >> $urandom_range(31), $urandom_range(2048),
                                   $urandom_range(4095));
            endcase
            for (int n = 0; n < 180; n++) begin
                if (n == 40 && (ph == 1 || ph == 4)) hold_req = 1;
                send_cmd(rand_cmd());
            end
            drain();
        end

        // large errors over long intervals, then clear the roll and yaw integrals in the deadband
        write_all($urandom, $urandom, $urandom, 0, $urandom_range(4095));
        for (int n = 0; n < 8; n++)
            send_cmd(mk_cmd(32767, -32768, $urandom, -32768, 32767, $urandom, $urandom, 65535));
        drain();
        apb_write(REG_DB, 32767);
        for (int n = 0; n < 4; n++)
            send_cmd(mk_cmd(32766, -32767, 0, 0, 0, 0, 300, 65535));
        drain();

        if (sb.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
